>>> rtl/core/ipv4nat_pkg.sv
// Shared types, constants and checksum function for the IPv4 NAT rewriter.
// No dependencies; every other file of the block refers to this package.

package ipv4nat_pkg;

   // Fixed addresses and header codes
   localparam logic [31:0] GUEST_ADDR     = 32'hA9FE_6402;   // 169.254.100.2
   localparam logic [15:0] FRAG_OFS_MASK  = 16'h1FFF;
   localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
   localparam logic [7:0]  PROTO_TCP      = 8'd6;
   localparam logic [7:0]  PROTO_UDP      = 8'd17;

   // Queue between the classify and rewrite sides
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int CSR_INDEX_W = 3;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_TRANSLATION_PRESENT = 3'd0,
      CSR_POOL_ADDRESS        = 3'd1,
      CSR_POOL_NETWORK        = 3'd2,
      CSR_SUBNET_MASK         = 3'd3,
      CSR_GATEWAY_ADDR        = 3'd4
   } csr_index_type;

   // What the rewrite side does with the L4 checksum
   typedef enum logic [1:0] {
      L4_KEEP       = 2'd0,
      L4_UPDATE     = 2'd1,
      L4_UPDATE_UDP = 2'd2   // zero result is sent as all ones
   } l4_mode_type;

   typedef struct packed {
      logic        translation_present;
      logic [31:0] pool_address;
      logic [31:0] pool_network;
      logic [31:0] subnet_mask;
      logic [31:0] gateway_addr;
   } cfg_type;

   // Classified packet, as held in the queue
   typedef struct packed {
      logic        drop;
      logic        act;
      logic        kind;
      l4_mode_type l4_mode;
      logic [31:0] from_addr;
      logic [31:0] to_addr;
      logic [31:0] src;
      logic [31:0] dst;
      logic [15:0] ipc;
      logic [15:0] l4c;
   } item_type;

   // Incremental ones'-complement update: HC' = ~(~HC + ~m + m')
   function automatic logic [15:0] csum_update(input logic [15:0] hc,
                                               input logic [31:0] from_addr,
                                               input logic [31:0] to_addr);
      logic [18:0] sum;
      logic [16:0] fold1;
      logic [15:0] fold2;
      sum = {3'b000, ~hc}
          + {3'b000, ~from_addr[31:16]}
          + {3'b000, ~from_addr[15:0]}
          + {3'b000, to_addr[31:16]}
          + {3'b000, to_addr[15:0]};
      fold1 = {1'b0, sum[15:0]} + {14'd0, sum[18:16]};
      fold2 = fold1[15:0] + {15'd0, fold1[16]};
      return ~fold2;
   endfunction

endpackage

>>> rtl/core/ipv4nat_if.sv
// Channel interfaces of the IPv4 NAT rewriter: request, response, register write.
// Depends on ipv4nat_pkg for the register index width.

interface ipv4nat_req_if;
   logic        valid;
   logic        ready;
   logic        kind;
   logic [15:0] ether_type;
   logic        header_complete;
   logic [15:0] fragment_word;
   logic [7:0]  ip_protocol;
   logic [15:0] ip_checksum;
   logic [31:0] source_address;
   logic [31:0] dest_address;
   logic [15:0] l4_checksum;
   logic        l4_checksum_present;

   modport source (output valid, kind, ether_type, header_complete, fragment_word,
                   ip_protocol, ip_checksum, source_address, dest_address,
                   l4_checksum, l4_checksum_present,
                   input ready);
   modport sink (input valid, kind, ether_type, header_complete, fragment_word,
                 ip_protocol, ip_checksum, source_address, dest_address,
                 l4_checksum, l4_checksum_present,
                 output ready);
endinterface

interface ipv4nat_rsp_if;
   logic        valid;
   logic        ready;
   logic        verdict;
   logic        rewritten;
   logic [31:0] new_source_address;
   logic [31:0] new_dest_address;
   logic [15:0] new_ip_checksum;
   logic [15:0] new_l4_checksum;

   modport source (output valid, verdict, rewritten, new_source_address,
                   new_dest_address, new_ip_checksum, new_l4_checksum,
                   input ready);
   modport sink (input valid, verdict, rewritten, new_source_address,
                 new_dest_address, new_ip_checksum, new_l4_checksum,
                 output ready);
endinterface

interface ipv4nat_csr_if;
   logic                                valid;
   logic                                ready;
   logic [ipv4nat_pkg::CSR_INDEX_W-1:0] index;
   logic [31:0]                         data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

>>> rtl/core/ipv4nat_front.sv
// Classify side: port registers and per-packet verdict / action decision.
// Depends on ipv4nat_pkg and ipv4nat_if.

module ipv4nat_front (
   input  logic                  clock,
   input  logic                  reset,
   ipv4nat_req_if.sink           req,
   ipv4nat_csr_if.sink           csr,
   input  logic                  queue_full,
   output logic                  push,
   output ipv4nat_pkg::item_type item
);

   ipv4nat_pkg::cfg_type cfg_ff, cfg_in;

   assign csr.ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr.valid) begin
         unique case (csr.index)
            ipv4nat_pkg::CSR_TRANSLATION_PRESENT: cfg_in.translation_present = csr.data[0];
            ipv4nat_pkg::CSR_POOL_ADDRESS:        cfg_in.pool_address        = csr.data;
            ipv4nat_pkg::CSR_POOL_NETWORK:        cfg_in.pool_network        = csr.data;
            ipv4nat_pkg::CSR_SUBNET_MASK:         cfg_in.subnet_mask         = csr.data;
            ipv4nat_pkg::CSR_GATEWAY_ADDR:        cfg_in.gateway_addr        = csr.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign req.ready = !queue_full;
   assign push      = req.valid && !queue_full;

   logic is_ipv4;
   logic isolated;
   logic first_frag;

   always_comb begin
      is_ipv4    = (req.ether_type == ipv4nat_pkg::ETHERTYPE_IPV4) && req.header_complete;
      isolated   = (cfg_ff.subnet_mask != 32'd0)
                && ((req.dest_address & cfg_ff.subnet_mask) == cfg_ff.pool_network)
                && (req.dest_address != cfg_ff.pool_address)
                && (req.dest_address != cfg_ff.gateway_addr);
      first_frag = (req.fragment_word & ipv4nat_pkg::FRAG_OFS_MASK) == 16'd0;

      item           = '0;
      item.kind      = req.kind;
      item.src       = req.source_address;
      item.dst       = req.dest_address;
      item.ipc       = req.ip_checksum;
      item.l4c       = req.l4_checksum;
      item.l4_mode   = ipv4nat_pkg::L4_KEEP;

      if (is_ipv4) begin
         if (!req.kind) begin
            if (req.source_address != ipv4nat_pkg::GUEST_ADDR || !cfg_ff.translation_present) begin
               item.drop = 1'b1;
            end else if (isolated) begin
               item.drop = 1'b1;
            end else begin
               item.act       = 1'b1;
               item.from_addr = req.source_address;
               item.to_addr   = cfg_ff.pool_address;
            end
         end else if (cfg_ff.translation_present && req.dest_address == cfg_ff.pool_address) begin
            item.act       = 1'b1;
            item.from_addr = req.dest_address;
            item.to_addr   = ipv4nat_pkg::GUEST_ADDR;
         end
      end

      if (item.act && first_frag) begin
         if (req.ip_protocol == ipv4nat_pkg::PROTO_TCP) begin
            if (!req.l4_checksum_present) begin
               item.drop = 1'b1;
            end else begin
               item.l4_mode = ipv4nat_pkg::L4_UPDATE;
            end
         end else if (req.ip_protocol == ipv4nat_pkg::PROTO_UDP) begin
            if (!req.l4_checksum_present) begin
               item.drop = 1'b1;
            end else if (req.l4_checksum != 16'd0) begin
               item.l4_mode = ipv4nat_pkg::L4_UPDATE_UDP;
            end
         end
      end
   end

endmodule

>>> rtl/core/ipv4nat_queue.sv
// Short register queue between the classify and rewrite sides.
// Depends on ipv4nat_pkg for the item type and depth.

module ipv4nat_queue (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  ipv4nat_pkg::item_type push_item,
   output logic                  full,
   input  logic                  pop,
   output logic                  head_valid,
   output ipv4nat_pkg::item_type head_item
);

   ipv4nat_pkg::item_type                entry_ff [ipv4nat_pkg::QUEUE_DEPTH];
   logic [ipv4nat_pkg::QPTR_W-1:0]       wr_ptr_ff, wr_ptr_in;
   logic [ipv4nat_pkg::QPTR_W-1:0]       rd_ptr_ff, rd_ptr_in;
   logic [ipv4nat_pkg::QCNT_W-1:0]       count_ff, count_in;

   localparam logic [ipv4nat_pkg::QPTR_W-1:0] LAST_PTR =
      ipv4nat_pkg::QPTR_W'(ipv4nat_pkg::QUEUE_DEPTH - 1);
   localparam logic [ipv4nat_pkg::QCNT_W-1:0] FULL_COUNT =
      ipv4nat_pkg::QCNT_W'(ipv4nat_pkg::QUEUE_DEPTH);

   assign full       = (count_ff == FULL_COUNT);
   assign head_valid = (count_ff != '0);
   assign head_item  = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

>>> rtl/core/ipv4nat_back.sv
// Rewrite side: incremental checksum update and registered response stage.
// Depends on ipv4nat_pkg and ipv4nat_if.

module ipv4nat_back (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  head_valid,
   input  ipv4nat_pkg::item_type head_item,
   output logic                  pop,
   ipv4nat_rsp_if.source         rsp
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic        verdict_ff, verdict_in;
   logic        rewritten_ff, rewritten_in;
   logic [31:0] nsrc_ff, nsrc_in;
   logic [31:0] ndst_ff, ndst_in;
   logic [15:0] nipc_ff, nipc_in;
   logic [15:0] nl4_ff, nl4_in;

   logic [15:0] ip_upd;
   logic [15:0] l4_upd;
   logic        done;

   // Output register frees whenever it is empty or being taken
   assign pop = head_valid && (!rsp_valid_ff || rsp.ready);

   always_comb begin
      ip_upd = ipv4nat_pkg::csum_update(head_item.ipc, head_item.from_addr, head_item.to_addr);
      l4_upd = ipv4nat_pkg::csum_update(head_item.l4c, head_item.from_addr, head_item.to_addr);
      done   = head_item.act && !head_item.drop;

      verdict_in   = head_item.drop;
      rewritten_in = done;
      nsrc_in      = head_item.src;
      ndst_in      = head_item.dst;
      nipc_in      = head_item.ipc;
      nl4_in       = head_item.l4c;
      if (done) begin
         nipc_in = ip_upd;
         if (head_item.kind) begin
            ndst_in = head_item.to_addr;
         end else begin
            nsrc_in = head_item.to_addr;
         end
         case (head_item.l4_mode)
            ipv4nat_pkg::L4_UPDATE:     nl4_in = l4_upd;
            ipv4nat_pkg::L4_UPDATE_UDP: nl4_in = (l4_upd == 16'd0) ? 16'hFFFF : l4_upd;
            default:                    nl4_in = head_item.l4c;
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      if (pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         verdict_ff   <= verdict_in;
         rewritten_ff <= rewritten_in;
         nsrc_ff      <= nsrc_in;
         ndst_ff      <= ndst_in;
         nipc_ff      <= nipc_in;
         nl4_ff       <= nl4_in;
      end
   end

   assign rsp.valid              = rsp_valid_ff;
   assign rsp.verdict            = verdict_ff;
   assign rsp.rewritten          = rewritten_ff;
   assign rsp.new_source_address = nsrc_ff;
   assign rsp.new_dest_address   = ndst_ff;
   assign rsp.new_ip_checksum    = nipc_ff;
   assign rsp.new_l4_checksum    = nl4_ff;

endmodule

>>> rtl/core/ipv4_address_nat_rewriter_core.sv
// Top level of the IPv4 NAT rewriter: classify side, queue and rewrite side.
// Depends on ipv4nat_pkg, ipv4nat_if, ipv4nat_front, ipv4nat_queue, ipv4nat_back.

// One parsed IPv4 header goes in per transfer on req_bus and exactly one verdict
// comes out per transfer on rsp_bus, in order. Sustained rate is one packet per
// clock while rsp_bus is ready; a request is written into the queue and is then
// moved into the output register, from which it is offered on rsp_bus.
// A packet that is not IPv4 or has a short header passes untouched.
// Ingress (kind 0) drops a source other than the guest address, drops when no
// translation is configured, drops pool-subnet destinations other than the pool
// address or gateway (unless the mask is zero), and otherwise rewrites the
// source to the pool address. Egress (kind 1) rewrites a destination equal to
// the pool address back to the guest address. The IP checksum gets the
// incremental update; on first fragments the TCP checksum, and a nonzero UDP
// checksum, are updated too. Dropped or untouched packets echo their fields.
// Port registers are written over csr_bus, which is always ready; write them
// only while no packet is in flight.

module ipv4_address_nat_rewriter_core (
   input  logic          clock,
   input  logic          reset,
   ipv4nat_req_if.sink   req_bus,
   ipv4nat_rsp_if.source rsp_bus,
   ipv4nat_csr_if.sink   csr_bus
);

   // Classify side to queue
   logic                  push;
   logic                  queue_full;
   ipv4nat_pkg::item_type push_item;

   // Queue to rewrite side
   logic                  pop;
   logic                  head_valid;
   ipv4nat_pkg::item_type head_item;

   // Decision is made combinationally on the request and captured in the queue,
   // so the request side only stalls once the queue is full.
   ipv4nat_front u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_bus),
      .csr        (csr_bus),
      .queue_full (queue_full),
      .push       (push),
      .item       (push_item)
   );

   // Two entries: enough for full rate while the response stage is not stalled
   ipv4nat_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // Checksum adders sit between queue head and the response register
   ipv4nat_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_item  (head_item),
      .pop        (pop),
      .rsp        (rsp_bus)
   );

endmodule
